### hw/rtl/char_lcd_expander_write_sequencer_top_macros.svh
// Assertion macros shared by the character LCD write sequencer RTL.
`ifndef CHAR_LCD_EXPANDER_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_EXPANDER_WRITE_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define LCDW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent in one cycle requires the consequent in the next.
`define LCDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LCDW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define LCDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/lcdw_pkg.sv
// Types and constants for the character LCD expander write sequencer.
`default_nettype none
package lcdw_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        FUNC_DATA   = 2'd0,
        FUNC_CMD    = 2'd1,
        FUNC_SETCUR = 2'd2
    } t_func;

    // Front control states
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    // Configuration register indexes
    localparam logic CFG_IDX_COLUMNS = 1'b0;
    localparam logic CFG_IDX_ROWS    = 1'b1;

    localparam logic [5:0] CFG_COLUMNS_RESET = 6'd16;
    localparam logic [2:0] CFG_ROWS_RESET    = 3'd2;

    // Expander bit assignments
    localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
    localparam logic [7:0] BIT_ENABLE    = 8'h04;
    localparam logic [7:0] BIT_SELECT    = 8'h01;
    localparam logic [7:0] SET_ADDR_CMD  = 8'h80;

    // Address geometry
    localparam logic [7:0] ROW_STRIDE    = 8'h40;
    localparam logic [7:0] HALF2_OFFSET  = 8'h80;
    localparam logic [5:0] COLS_16       = 6'd16;
    localparam logic [5:0] ONE_ROW_SPLIT = 6'd8;
    localparam logic [2:0] ROWS_ONE      = 3'd1;
    localparam logic [2:0] ROWS_TWO      = 3'd2;
    localparam logic [2:0] ROWS_FOUR     = 3'd4;

    localparam logic [7:0] ROW_BASE_16 [4] = '{8'h00, 8'h40, 8'h10, 8'h50};
    localparam logic [7:0] ROW_BASE_20 [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // Waits after each expander byte, in microseconds
    localparam logic [5:0] WAIT_NONE   = 6'd0;
    localparam logic [5:0] WAIT_PULSE  = 6'd1;
    localparam logic [5:0] WAIT_SETTLE = 6'd50;

    // Output steps of one request
    localparam logic [2:0] STEP_HI_PLAIN = 3'd0;
    localparam logic [2:0] STEP_HI_EN    = 3'd1;
    localparam logic [2:0] STEP_HI_DONE  = 3'd2;
    localparam logic [2:0] STEP_LO_PLAIN = 3'd3;
    localparam logic [2:0] STEP_LO_EN    = 3'd4;
    localparam logic [2:0] STEP_LO_DONE  = 3'd5;

    // Last cycle of the remainder loop (two quotient bits per cycle)
    localparam logic [1:0] DIV_LAST = 2'd3;

    // Geometry registers
    typedef struct packed {
        logic [5:0] columns;
        logic [2:0] rows;
    } t_cfg;

    // One queued byte for the back end
    typedef struct packed {
        logic [7:0] value;
        logic       sel;
    } t_q_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

### hw/rtl/lcdw_front.sv
// Front end: accepts requests, computes cursor addresses, pushes bytes to the queue.
`default_nettype none
`include "char_lcd_expander_write_sequencer_top_macros.svh"
module lcdw_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire lcdw_pkg::t_func     i_func,
    input  wire logic [7:0]          i_byte,
    input  wire logic [1:0]          i_row,
    input  wire logic [7:0]          i_column,
    input  wire lcdw_pkg::t_cfg      i_cfg,
    input  wire lcdw_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output lcdw_pkg::t_q_entry       o_entry
);
    import lcdw_pkg::*;

    t_front_state r_state, n_state;
    logic [7:0]   r_dvd, n_dvd;
    logic [5:0]   r_rem, n_rem;
    logic [1:0]   r_cnt, n_cnt;
    logic [1:0]   r_row, n_row;
    logic [7:0]   r_col, n_col;

    logic         accept;
    logic [5:0]   rem1, rem2;
    logic [7:0]   col;
    logic [4:0]   half;
    logic [5:0]   half2;
    logic [7:0]   addr;

    // One restoring remainder step
    function automatic logic [5:0] rem_step(input logic [5:0] rem, input logic b,
                                            input logic [5:0] div);
        logic [6:0] t;
        t = {rem, b};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[5:0];
    endfunction

    // Same condition as valid && ready, built from state so ready never feeds back
    assign accept = i_valid && !i_q_status.full && (r_state == FS_IDLE);

    // Two remainder bits per cycle
    assign rem1 = rem_step(r_rem, r_dvd[7], i_cfg.columns);
    assign rem2 = rem_step(rem1, r_dvd[6], i_cfg.columns);

    // Address from wrapped column and geometry
    assign col   = (i_cfg.columns == 6'd0) ? r_col : {2'b00, r_rem};
    assign half  = i_cfg.columns[5:1];
    assign half2 = {half, 1'b0};

    always_comb begin
        addr = col;
        case (i_cfg.rows)
            ROWS_ONE: begin
                if (i_cfg.columns > ONE_ROW_SPLIT) begin
                    if (col >= {2'b00, half2}) begin
                        addr = col - {2'b00, half2} + HALF2_OFFSET;
                    end else if (col >= {3'b000, half}) begin
                        addr = col - {3'b000, half} + ROW_STRIDE;
                    end
                end
            end
            ROWS_TWO: begin
                addr = col + {r_row, 6'd0};
            end
            ROWS_FOUR: begin
                if (i_cfg.columns == COLS_16) begin
                    addr = col + ROW_BASE_16[r_row];
                end else begin
                    addr = col + ROW_BASE_20[r_row];
                end
            end
            default: begin
                addr = col;
            end
        endcase
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_row   = r_row;
        n_col   = r_col;
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_entry = '{value: i_byte, sel: 1'b0};
        case (r_state)
            FS_IDLE: begin
                o_ready = !i_q_status.full;
                if (accept) begin
                    case (i_func)
                        FUNC_DATA: begin
                            o_push  = 1'b1;
                            o_entry = '{value: i_byte, sel: 1'b1};
                        end
                        FUNC_CMD: begin
                            o_push  = 1'b1;
                            o_entry = '{value: i_byte, sel: 1'b0};
                        end
                        FUNC_SETCUR: begin
                            n_dvd   = i_column;
                            n_col   = i_column;
                            n_rem   = 6'd0;
                            n_cnt   = 2'd0;
                            n_row   = i_row;
                            n_state = FS_DIV;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            FS_DIV: begin
                n_rem = rem2;
                n_dvd = {r_dvd[5:0], 2'b00};
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                o_entry = '{value: SET_ADDR_CMD | addr, sel: 1'b0};
                if (!i_q_status.full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_row <= n_row;
        r_col <= n_col;
    end

    `LCDW_ASSERT_NEXT(a_setcur_divides, i_clk, i_rst_n,
        accept && (i_func == FUNC_SETCUR), r_state == FS_DIV,
        "set cursor did not start remainder")
    `LCDW_ASSERT_ALWAYS(a_push_room, i_clk, i_rst_n,
        !(o_push && i_q_status.full), "front pushed into full queue")

endmodule
`default_nettype wire

### hw/rtl/lcdw_queue.sv
// Small FIFO of command/data bytes between front and back ends.
`default_nettype none
`include "char_lcd_expander_write_sequencer_top_macros.svh"
module lcdw_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire lcdw_pkg::t_q_entry  i_entry,
    input  wire logic                i_pop,
    output lcdw_pkg::t_q_entry       o_entry,
    output lcdw_pkg::t_q_status      o_status
);
    import lcdw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_entry         = r_mem[r_rptr];
    assign o_status.full   = (r_count == CNT_W'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    `LCDW_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_status.empty), "pop from empty queue")
    `LCDW_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count past depth")

endmodule
`default_nettype wire

### hw/rtl/lcdw_back.sv
// Back end: turns each queued byte into six expander bytes with waits.
`default_nettype none
`include "char_lcd_expander_write_sequencer_top_macros.svh"
module lcdw_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lcdw_pkg::t_q_status i_q_status,
    input  wire lcdw_pkg::t_q_entry  i_q_entry,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_byte,
    output logic [5:0]               o_wait,
    output logic                     o_last
);
    import lcdw_pkg::*;

    logic       r_active;
    logic [2:0] r_step;
    t_q_entry   r_entry;

    logic       done_last;
    logic [7:0] base;
    logic [3:0] nibble;

    assign done_last = r_active && i_ready && (r_step == STEP_LO_DONE);
    assign o_pop     = !i_q_status.empty && (!r_active || done_last);
    assign o_valid   = r_active;
    assign o_last    = (r_step == STEP_LO_DONE);

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= STEP_HI_PLAIN;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_step   <= STEP_HI_PLAIN;
        end else if (r_active && i_ready) begin
            if (r_step == STEP_LO_DONE) begin
                r_active <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_q_entry;
        end
    end

    // Expander byte for the current step
    assign nibble = (r_step < STEP_LO_PLAIN) ? r_entry.value[7:4] : r_entry.value[3:0];
    assign base   = {nibble, 4'h0} | BIT_BACKLIGHT | (r_entry.sel ? BIT_SELECT : 8'h00);

    always_comb begin
        o_byte = base;
        o_wait = WAIT_NONE;
        case (r_step)
            STEP_HI_PLAIN, STEP_LO_PLAIN: begin
                o_byte = base;
                o_wait = WAIT_NONE;
            end
            STEP_HI_EN, STEP_LO_EN: begin
                o_byte = base | BIT_ENABLE;
                o_wait = WAIT_PULSE;
            end
            STEP_HI_DONE, STEP_LO_DONE: begin
                o_byte = base & ~BIT_ENABLE;
                o_wait = WAIT_SETTLE;
            end
            default: begin
                o_byte = base;
                o_wait = WAIT_NONE;
            end
        endcase
    end

    `LCDW_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_active && !i_ready, $stable(r_step) && $stable(r_entry) && r_active, "stalled output changed")
    `LCDW_ASSERT_NEXT(a_reload, i_clk, i_rst_n, done_last && !i_q_status.empty, r_active && (r_step == STEP_HI_PLAIN), "next request not started after last byte")

endmodule
`default_nettype wire

### hw/rtl/char_lcd_expander_write_sequencer_top.sv
// Top level of the character LCD expander write sequencer.
//
//  Channel | Dir | Handshake                   | Payload
//  --------+-----+-----------------------------+----------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser func; tdata byte, row, column
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tdata expander byte, wait; tlast
//  cfg     | in  | i_cfg_we                    | i_cfg_index, i_cfg_wdata
//
// Data and command requests are queued in the same cycle that they are accepted. A set-cursor
// request holds the front through accept, the remainder loop (two bits at a time for column
// mod column_count) and the address/queue step, which waits while the queue is full.
// The back end sends six transfers per request, one per cycle while m_axis is not stalled.
// Synchronous active-low reset empties the queue and sets 16 columns, 2 rows.
// A stalled m_axis holds its byte; the front keeps accepting until the queue is full.
`default_nettype none
module char_lcd_expander_write_sequencer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] byte_value, [9:8] row, [17:10] column
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    // expander byte stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] expander_byte, [13:8] wait_us
    output logic             m_axis_tlast,   // last
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [5:0]  i_cfg_wdata
);
    import lcdw_pkg::*;

    t_cfg      r_cfg;
    t_q_status q_status;
    t_q_entry  push_entry, head_entry;
    logic      push, pop;
    logic [7:0] out_byte;
    logic [5:0] out_wait;

    // Geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns <= CFG_COLUMNS_RESET;
            r_cfg.rows    <= CFG_ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_COLUMNS: r_cfg.columns <= i_cfg_wdata;
                CFG_IDX_ROWS:    r_cfg.rows    <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    lcdw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (t_func'(s_axis_tuser)),
        .i_byte     (s_axis_tdata[7:0]),
        .i_row      (s_axis_tdata[9:8]),
        .i_column   (s_axis_tdata[17:10]),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    lcdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    lcdw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_entry  (head_entry),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (out_byte),
        .o_wait     (out_wait),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_wait, out_byte};

endmodule
`default_nettype wire

### tb/char_lcd_expander_write_sequencer_checker.sv
// Checker for the LCD write sequencer: predicts expander transfers and compares them.
module char_lcd_expander_write_sequencer_checker
    import lcdw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] byte_value, [9:8] row, [17:10] column
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [7:0] expander_byte, [13:8] wait_us
    input  wire logic        m_axis_tlast,   // last
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [5:0]  i_cfg_wdata,
    output int               o_fail_count,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic [5:0] wait_us;
        logic       is_last;
    } t_lcd_beat;

    t_lcd_beat  pending_beats[$];
    logic [5:0] geo_columns;
    logic [2:0] geo_rows;
    int         fails;

    // Display RAM address for a set-cursor request under the current geometry
    function automatic logic [7:0] cursor_ram_address(input logic [1:0] row,
                                                      input logic [7:0] column);
        int cols;
        int col;
        int half;
        int addr;
        cols = int'(geo_columns);
        col  = int'(column);
        // zero width leaves the column unwrapped
        if (cols != 0) col = col % cols;
        addr = col;
        case (geo_rows)
            ROWS_ONE: begin
                // wide single-row panels are split into two halves
                if (cols > int'(ONE_ROW_SPLIT)) begin
                    half = cols / 2;
                    addr = (col % half) + (col / half) * int'(ROW_STRIDE);
                end
            end
            ROWS_TWO: addr = col + int'(row) * int'(ROW_STRIDE);
            ROWS_FOUR: begin
                if (geo_columns == COLS_16) addr = col + int'(ROW_BASE_16[row]);
                else addr = col + int'(ROW_BASE_20[row]);
            end
            default: ;
        endcase
        return 8'(addr);
    endfunction

    // Three expander bytes for one nibble: plain, enable high, enable low
    function automatic void push_nibble(input logic [7:0] nib, input logic sel,
                                        input logic closing);
        logic [7:0] base;
        base = (nib & 8'hF0) | BIT_BACKLIGHT | (sel ? BIT_SELECT : 8'h00);
        pending_beats.push_back('{base, WAIT_NONE, 1'b0});
        pending_beats.push_back('{base | BIT_ENABLE, WAIT_PULSE, 1'b0});
        pending_beats.push_back('{base & ~BIT_ENABLE, WAIT_SETTLE, closing});
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fails++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endtask

    // Track geometry, compare output transfers, predict from request transfers
    always @(posedge i_clk) begin
        t_lcd_beat  beat;
        logic [7:0] cmd;
        logic       sel;
        logic       takes;
        if (!i_rst_n) begin
            geo_columns = CFG_COLUMNS_RESET;
            geo_rows    = CFG_ROWS_RESET;
            pending_beats.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_COLUMNS) geo_columns = i_cfg_wdata;
                else geo_rows = i_cfg_wdata[2:0];
            end

            // output side first so a fresh request cannot cover a stray transfer
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_beats.size() == 0) begin
                    fails++;
                    $error("unexpected output transfer: tdata 0x%0h, tlast %0b",
                           m_axis_tdata, m_axis_tlast);
                end else begin
                    beat = pending_beats.pop_front();
                    check_field("expander_byte", int'(beat.expander_byte),
                                int'(m_axis_tdata[7:0]));
                    check_field("wait_us", int'(beat.wait_us), int'(m_axis_tdata[13:8]));
                    check_field("last", int'(beat.is_last), int'(m_axis_tlast));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                takes = 1'b1;
                cmd   = 8'h00;
                sel   = 1'b0;
                case (s_axis_tuser)
                    FUNC_DATA: begin
                        cmd = s_axis_tdata[7:0];
                        sel = 1'b1;
                    end
                    FUNC_CMD: cmd = s_axis_tdata[7:0];
                    FUNC_SETCUR:
                        cmd = SET_ADDR_CMD |
                              cursor_ram_address(s_axis_tdata[9:8], s_axis_tdata[17:10]);
                    // unused code: dropped without output
                    default: takes = 1'b0;
                endcase
                if (takes) begin
                    push_nibble(cmd, sel, 1'b0);
                    push_nibble(cmd << 4, sel, 1'b1);
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_beats.size();
    end

endmodule

### tb/char_lcd_expander_write_sequencer_top_tb.sv
// Testbench top for the LCD write sequencer: stimulus, flow control and verdict.
module char_lcd_expander_write_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdw_pkg::*;

    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam int         ITEMS_PER_PHASE = 19;
    localparam int         NUM_PHASES      = 8;
    localparam int         SETTLE_CYCLES   = 20;
    localparam int         DRAIN_LIMIT     = 20000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [7:0] byte_value, [9:8] row, [17:10] column
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] expander_byte, [13:8] wait_us
    logic        m_axis_tlast;         // last
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_IDX_COLUMNS;
    logic [5:0]  i_cfg_wdata   = '0;
    int          fail_count;
    int          outstanding;

    // Flow-control mix: sender idle and receiver stall, percent of cycles
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int mode_src_idle [4] = '{0, 85, 0, 9};
    int mode_snk_stall[4] = '{0, 0, 85, 9};

    // Geometry per random phase; negative means pick at random
    int phase_cols[NUM_PHASES] = '{1, 40, 16, 20, 63, 0, 9, -1};
    int phase_rows[NUM_PHASES] = '{1, 4, 4, 2, 7, 1, 1, -1};

    char_lcd_expander_write_sequencer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    char_lcd_expander_write_sequencer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // One request transfer, with a random idle gap in front of it
    task automatic send_request(input logic [1:0] func, input logic [7:0] byte_val,
                                input logic [1:0] row, input logic [7:0] column);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, column, row, byte_val};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait for the block to go idle, then write both geometry registers
    task automatic reconfigure(input int cols, input int rows);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_COLUMNS;
        i_cfg_wdata <= 6'(cols);
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_ROWS;
        i_cfg_wdata <= {3'b0, 3'(rows)};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Hard stop if the run hangs
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int         cols;
        int         rows;
        int         accepted;
        int         drain_cycles;
        logic [1:0] func;
        logic [7:0] column;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, both kinds, ignored code, every address mapping
        reconfigure(16, 2);
        send_request(FUNC_DATA, 8'h00, 2'd0, 8'h00);
        send_request(FUNC_DATA, 8'hFF, 2'd3, 8'hFF);
        send_request(FUNC_CMD, 8'h00, 2'd0, 8'h00);
        send_request(FUNC_CMD, 8'hFF, 2'd3, 8'hFF);
        send_request(FUNC_DATA, 8'h5A, 2'd1, 8'hA5);
        send_request(FUNC_UNUSED, 8'hC3, 2'd2, 8'h3C);
        send_request(FUNC_SETCUR, 8'h00, 2'd0, 8'd0);
        send_request(FUNC_SETCUR, 8'hFF, 2'd1, 8'd15);
        send_request(FUNC_SETCUR, 8'h00, 2'd3, 8'd255);
        send_request(FUNC_SETCUR, 8'h00, 2'd2, 8'd16);
        // zero width: no wrap, address sum overflows 8 bits
        reconfigure(0, 2);
        send_request(FUNC_SETCUR, 8'h00, 2'd3, 8'd255);
        send_request(FUNC_SETCUR, 8'h00, 2'd0, 8'd200);
        // odd single-row width: last column lands on 0x80
        reconfigure(17, 1);
        send_request(FUNC_SETCUR, 8'h00, 2'd0, 8'd16);
        send_request(FUNC_SETCUR, 8'h00, 2'd0, 8'd12);
        reconfigure(8, 1);
        send_request(FUNC_SETCUR, 8'h00, 2'd1, 8'd7);
        reconfigure(16, 4);
        send_request(FUNC_SETCUR, 8'h00, 2'd2, 8'd5);
        send_request(FUNC_SETCUR, 8'h00, 2'd3, 8'd15);
        reconfigure(20, 4);
        send_request(FUNC_SETCUR, 8'h00, 2'd2, 8'd19);
        send_request(FUNC_SETCUR, 8'h00, 2'd3, 8'd0);
        // unmapped row counts fall back to the column alone
        reconfigure(40, 3);
        send_request(FUNC_SETCUR, 8'h00, 2'd3, 8'd39);
        reconfigure(1, 0);
        send_request(FUNC_SETCUR, 8'h00, 2'd0, 8'd255);

        // Random phases over geometries and flow-control mixes
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            cols = (phase_cols[phase] < 0) ? int'($urandom_range(63)) : phase_cols[phase];
            rows = (phase_rows[phase] < 0) ? int'($urandom_range(7)) : phase_rows[phase];
            reconfigure(cols, rows);
            src_idle_pct  = mode_src_idle[phase % 4];
            snk_stall_pct = mode_snk_stall[phase % 4];
            accepted = 0;
            while (accepted < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 5) begin
                    send_request(FUNC_UNUSED, 8'($urandom_range(255)),
                                 2'($urandom_range(3)), 8'($urandom_range(255)));
                end else begin
                    func = 2'($urandom_range(2));
                    // half the columns stay in range, half exercise the wrap
                    if ($urandom_range(1) == 0 && cols > 0) begin
                        column = 8'($urandom_range(cols - 1));
                    end else begin
                        column = 8'($urandom_range(255));
                    end
                    send_request(func, 8'($urandom_range(255)), 2'($urandom_range(3)),
                                 column);
                    accepted++;
                end
            end
        end

        // Drain, then give stray transfers a chance to show up
        s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        @(posedge i_clk);
        while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
